@@ rtl/postfix_stack_evaluator_core_assert.svh @@
// ----------------------------------------------------------------------------
// Postfix stack evaluator assertion macros
// Shorthand for the clocked checks used inside the evaluator's modules.
// ----------------------------------------------------------------------------
`ifndef POSTFIX_STACK_EVALUATOR_CORE_ASSERT_SVH
`define POSTFIX_STACK_EVALUATOR_CORE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define PSE_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/pse_pkg.sv @@
// ----------------------------------------------------------------------------
// Postfix stack evaluator package
// Sizes, character codes, status codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package pse_pkg;

    localparam int STACK_DEPTH = 8;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int WORD_W      = 32;
    localparam int SYM_W       = 8;
    localparam int DEPTH_W     = 4;
    localparam int STAT_W      = 3;
    localparam int DIV_STEPS   = WORD_W;
    localparam int STEP_W      = $clog2(DIV_STEPS);
    localparam int OUT_DATA_W  = 40;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STACK_DEPTH);
    localparam logic [CNT_W-1:0] TWO_CNT   = CNT_W'(2);

    localparam logic [SYM_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [SYM_W-1:0] CH_NINE  = 8'h39;
    localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [SYM_W-1:0] CH_SLASH = 8'h2F;

    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_OVERFLOW  = 3'd1;
    localparam logic [STAT_W-1:0] ST_UNDERFLOW = 3'd2;
    localparam logic [STAT_W-1:0] ST_DIVZERO   = 3'd3;
    localparam logic [STAT_W-1:0] ST_IGNORED   = 3'd4;

    typedef struct packed {
        logic load_in;
        logic set_ovf;
        logic push_digit;
        logic capture;
        logic exec;
        logic div_start;
        logic div_step;
        logic push_res;
        logic emit;
    } t_pse_cmd;

    typedef struct packed {
        logic is_digit;
        logic is_op;
        logic is_div;
        logic full;
        logic b_zero;
        logic div_last;
        logic out_free;
    } t_pse_sts;

    function automatic logic f_is_digit(input logic [SYM_W-1:0] sym);
        return (sym >= CH_ZERO) && (sym <= CH_NINE);
    endfunction

    function automatic logic f_is_oper(input logic [SYM_W-1:0] sym);
        return (sym == CH_PLUS) || (sym == CH_MINUS) || (sym == CH_STAR) ||
               (sym == CH_SLASH);
    endfunction

endpackage

@@ rtl/postfix_stack_evaluator_core.sv @@
// ----------------------------------------------------------------------------
// Postfix stack evaluator
// Evaluates a postfix expression one character per request on a bounded stack.
// ----------------------------------------------------------------------------
// Input stream: one ASCII character per request in tdata, tlast marks the last
// character of an expression. Digits are pushed, + - * / pop two operands and
// push the 32-bit result, anything else is ignored.
// Output stream: one result per input request, carrying the stack top and depth
// in tdata, the status code in tuser and the end-of-expression flag in tlast.
// Per request the controller steps through IDLE, DECODE and DONE for a digit or
// ignored character, adding READ, EXEC and PUSH for + - * and for a division by
// zero; any other division also runs the one-bit-per-cycle restoring divider
// (32 steps) in DIV between EXEC and PUSH. READ is there because the stack
// memory's read is registered: it waits for the left operand.
// Only one request is in flight; the result sits in an output register, so the
// next request is taken while a result still waits. If the receiver stalls with
// a result pending, the following request finishes its work and then waits.
// Reset (synchronous, active low) empties the stack and drops any pending result.
// ----------------------------------------------------------------------------
module postfix_stack_evaluator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] symbol
    input  logic        i_s_axis_tlast,   // expr_end

    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // [31:0] top_value, [35:32] stack_depth, zero fill
    output logic [2:0]  o_m_axis_tuser,   // [2:0] status
    output logic        o_m_axis_tlast    // final_result
);

    pse_pkg::t_pse_cmd                  w_cmd;
    pse_pkg::t_pse_sts                  w_sts;
    logic [pse_pkg::WORD_W-1:0]         w_top;
    logic [pse_pkg::DEPTH_W-1:0]        w_depth;
    logic [pse_pkg::STAT_W-1:0]         w_status;

    pse_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    pse_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_symbol     (i_s_axis_tdata),
        .i_end        (i_s_axis_tlast),
        .i_out_ready  (i_m_axis_tready),
        .o_out_valid  (o_m_axis_tvalid),
        .o_out_top    (w_top),
        .o_out_depth  (w_depth),
        .o_out_status (w_status),
        .o_out_final  (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {4'b0000, w_depth, w_top};
    assign o_m_axis_tuser = w_status;

endmodule

@@ rtl/pse_ram.sv @@
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/pse_ctrl.sv @@
// ----------------------------------------------------------------------------
// Postfix stack evaluator controller
// Sequences decode, operand fetch, execution, push and result hand-off.
// ----------------------------------------------------------------------------
module pse_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  pse_pkg::t_pse_sts i_sts,
    output pse_pkg::t_pse_cmd o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_EXEC   = 3'd3;
    localparam logic [2:0] S_DIV    = 3'd4;
    localparam logic [2:0] S_PUSH   = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0]        r_state;
    logic [2:0]        n_state;
    pse_pkg::t_pse_cmd w_cmd;

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.load_in = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.is_digit) begin
                    if (i_sts.full) begin
                        w_cmd.set_ovf = 1'b1;
                    end else begin
                        w_cmd.push_digit = 1'b1;
                    end
                    n_state = S_DONE;
                end else if (i_sts.is_op) begin
                    // The left operand read is launched here and lands in S_READ.
                    n_state = S_READ;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_READ: begin
                w_cmd.capture = 1'b1;
                n_state       = S_EXEC;
            end
            S_EXEC: begin
                if (i_sts.is_div && !i_sts.b_zero) begin
                    w_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    w_cmd.exec = 1'b1;
                    n_state    = S_PUSH;
                end
            end
            S_DIV: begin
                w_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                w_cmd.push_res = 1'b1;
                n_state        = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    w_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd      = w_cmd;

endmodule

@@ rtl/pse_dpath.sv @@
// ----------------------------------------------------------------------------
// Postfix stack evaluator datapath
// Stack memory, cached top, operand registers, ALU, serial divider, result register.
// ----------------------------------------------------------------------------
`include "postfix_stack_evaluator_core_assert.svh"

module pse_dpath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pse_pkg::t_pse_cmd                   i_cmd,
    output pse_pkg::t_pse_sts                   o_sts,
    input  logic [pse_pkg::SYM_W-1:0]           i_symbol,
    input  logic                                i_end,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [pse_pkg::WORD_W-1:0]          o_out_top,
    output logic [pse_pkg::DEPTH_W-1:0]         o_out_depth,
    output logic [pse_pkg::STAT_W-1:0]          o_out_status,
    output logic                                o_out_final
);

    // Control state
    logic [pse_pkg::CNT_W-1:0]   r_count, n_count;
    logic                        r_out_valid, n_out_valid;

    // Request and operand registers
    logic [pse_pkg::SYM_W-1:0]   r_sym, n_sym;
    logic                        r_end, n_end;
    logic [pse_pkg::STAT_W-1:0]  r_status, n_status;
    logic [pse_pkg::WORD_W-1:0]  r_top, n_top;
    logic [pse_pkg::WORD_W-1:0]  r_a, n_a;
    logic [pse_pkg::WORD_W-1:0]  r_b, n_b;
    logic [pse_pkg::CNT_W-1:0]   r_base, n_base;
    logic [pse_pkg::WORD_W-1:0]  r_res, n_res;
    logic                        r_neg, n_neg;
    logic                        r_use_div, n_use_div;

    // Divider
    logic [pse_pkg::WORD_W-1:0]  r_quo, n_quo;
    logic [pse_pkg::WORD_W:0]    r_rem, n_rem;
    logic [pse_pkg::WORD_W:0]    r_den, n_den;
    logic [pse_pkg::STEP_W-1:0]  r_step, n_step;

    // Result register
    logic [pse_pkg::WORD_W-1:0]  r_out_top, n_out_top;
    logic [pse_pkg::DEPTH_W-1:0] r_out_depth, n_out_depth;
    logic [pse_pkg::STAT_W-1:0]  r_out_status, n_out_status;
    logic                        r_out_final, n_out_final;

    logic                        w_under;
    logic [pse_pkg::WORD_W-1:0]  w_right;
    logic [pse_pkg::WORD_W-1:0]  w_left;
    logic [pse_pkg::CNT_W-1:0]   w_cnt_m2;
    logic [pse_pkg::WORD_W-1:0]  w_abs_b;
    logic [pse_pkg::WORD_W-1:0]  w_prod;
    logic [pse_pkg::WORD_W+1:0]  w_rem_sh;
    logic [pse_pkg::WORD_W+1:0]  w_rem_sub;
    logic                        w_qbit;
    logic [pse_pkg::WORD_W-1:0]  w_push_val;
    logic [pse_pkg::WORD_W-1:0]  w_digit_val;
    logic [31:0]                 w_cnt_ext;
    logic                        w_out_free;

    logic                        w_we;
    logic [pse_pkg::ADDR_W-1:0]  w_waddr;
    logic [pse_pkg::WORD_W-1:0]  w_wdata;
    logic [pse_pkg::ADDR_W-1:0]  w_raddr;
    logic [pse_pkg::WORD_W-1:0]  w_rdata;

    pse_ram #(
        .WIDTH (pse_pkg::WORD_W),
        .DEPTH (pse_pkg::STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_cnt_m2    = r_count - pse_pkg::TWO_CNT;
    assign w_raddr     = w_cnt_m2[pse_pkg::ADDR_W-1:0];
    assign w_under     = (r_count < pse_pkg::TWO_CNT);
    assign w_right     = (r_count != '0) ? r_top : '0;
    assign w_left      = w_under ? '0 : w_rdata;
    assign w_abs_b     = r_b[pse_pkg::WORD_W-1] ? (~r_b + 1'b1) : r_b;
    assign w_prod      = r_a * r_b;
    assign w_digit_val = pse_pkg::WORD_W'(r_sym - pse_pkg::CH_ZERO);
    assign w_push_val  = r_use_div ? (r_neg ? (~r_quo + 1'b1) : r_quo) : r_res;
    assign w_cnt_ext   = 32'(r_count);
    assign w_out_free  = !r_out_valid || i_out_ready;

    // One restoring step: shift in the next dividend bit and try the subtraction.
    assign w_rem_sh  = {r_rem, r_quo[pse_pkg::WORD_W-1]};
    assign w_rem_sub = w_rem_sh - {1'b0, r_den};
    assign w_qbit    = !w_rem_sub[pse_pkg::WORD_W+1];

    assign w_we    = i_cmd.push_digit || i_cmd.push_res;
    assign w_waddr = i_cmd.push_res ? r_base[pse_pkg::ADDR_W-1:0]
                                    : r_count[pse_pkg::ADDR_W-1:0];
    assign w_wdata = i_cmd.push_res ? w_push_val : w_digit_val;

    always_comb begin
        n_count      = r_count;
        n_out_valid  = r_out_valid;
        n_sym        = r_sym;
        n_end        = r_end;
        n_status     = r_status;
        n_top        = r_top;
        n_a          = r_a;
        n_b          = r_b;
        n_base       = r_base;
        n_res        = r_res;
        n_neg        = r_neg;
        n_use_div    = r_use_div;
        n_quo        = r_quo;
        n_rem        = r_rem;
        n_den        = r_den;
        n_step       = r_step;
        n_out_top    = r_out_top;
        n_out_depth  = r_out_depth;
        n_out_status = r_out_status;
        n_out_final  = r_out_final;

        if (i_cmd.load_in) begin
            n_sym    = i_symbol;
            n_end    = i_end;
            n_status = (pse_pkg::f_is_digit(i_symbol) || pse_pkg::f_is_oper(i_symbol))
                       ? pse_pkg::ST_OK : pse_pkg::ST_IGNORED;
        end

        if (i_cmd.set_ovf) begin
            n_status = pse_pkg::ST_OVERFLOW;
        end

        if (i_cmd.push_digit) begin
            n_top   = w_digit_val;
            n_count = r_count + 1'b1;
        end

        // Both pops happen here: the right operand is the cached top, the left one
        // comes from the memory read launched in the previous cycle.
        if (i_cmd.capture) begin
            n_a       = w_left;
            n_b       = w_right;
            n_base    = w_under ? '0 : w_cnt_m2;
            n_neg     = w_left[pse_pkg::WORD_W-1] ^ w_right[pse_pkg::WORD_W-1];
            n_use_div = 1'b0;
            if (w_under) begin
                n_status = pse_pkg::ST_UNDERFLOW;
            end else if ((r_sym == pse_pkg::CH_SLASH) && (w_right == '0)) begin
                n_status = pse_pkg::ST_DIVZERO;
            end else begin
                n_status = pse_pkg::ST_OK;
            end
        end

        if (i_cmd.exec) begin
            case (r_sym)
                pse_pkg::CH_PLUS:  n_res = r_a + r_b;
                pse_pkg::CH_MINUS: n_res = r_a - r_b;
                pse_pkg::CH_STAR:  n_res = w_prod;
                default:           n_res = '0;
            endcase
        end

        // Dividend |2a+1| and divisor |2b|; the quotient sign is applied on push.
        if (i_cmd.div_start) begin
            n_quo     = {r_a[pse_pkg::WORD_W-1] ? ~r_a[pse_pkg::WORD_W-2:0]
                                                : r_a[pse_pkg::WORD_W-2:0], 1'b1};
            n_rem     = '0;
            n_den     = {w_abs_b, 1'b0};
            n_step    = '0;
            n_use_div = 1'b1;
        end

        if (i_cmd.div_step) begin
            n_rem  = w_qbit ? w_rem_sub[pse_pkg::WORD_W:0] : w_rem_sh[pse_pkg::WORD_W:0];
            n_quo  = {r_quo[pse_pkg::WORD_W-2:0], w_qbit};
            n_step = r_step + 1'b1;
        end

        if (i_cmd.push_res) begin
            n_top   = w_push_val;
            n_count = r_base + 1'b1;
        end

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (i_cmd.emit) begin
            n_out_valid  = 1'b1;
            n_out_top    = (r_count != '0) ? r_top : '0;
            n_out_depth  = w_cnt_ext[pse_pkg::DEPTH_W-1:0];
            n_out_status = r_status;
            n_out_final  = r_end;
            if (r_end) begin
                n_count = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sym        <= n_sym;
        r_end        <= n_end;
        r_status     <= n_status;
        r_top        <= n_top;
        r_a          <= n_a;
        r_b          <= n_b;
        r_base       <= n_base;
        r_res        <= n_res;
        r_neg        <= n_neg;
        r_use_div    <= n_use_div;
        r_quo        <= n_quo;
        r_rem        <= n_rem;
        r_den        <= n_den;
        r_step       <= n_step;
        r_out_top    <= n_out_top;
        r_out_depth  <= n_out_depth;
        r_out_status <= n_out_status;
        r_out_final  <= n_out_final;
    end

    assign o_sts.is_digit = pse_pkg::f_is_digit(r_sym);
    assign o_sts.is_op    = pse_pkg::f_is_oper(r_sym);
    assign o_sts.is_div   = (r_sym == pse_pkg::CH_SLASH);
    assign o_sts.full     = (r_count == pse_pkg::DEPTH_CNT);
    assign o_sts.b_zero   = (r_b == '0);
    assign o_sts.div_last = (r_step == pse_pkg::STEP_W'(pse_pkg::DIV_STEPS - 1));
    assign o_sts.out_free = w_out_free;

    assign o_out_valid  = r_out_valid;
    assign o_out_top    = r_out_top;
    assign o_out_depth  = r_out_depth;
    assign o_out_status = r_out_status;
    assign o_out_final  = r_out_final;

    `PSE_ASSERT_SAME(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= pse_pkg::DEPTH_CNT, "stack count beyond depth")
    `PSE_ASSERT_SAME(a_digit_fits, i_clk, i_rst_n, i_cmd.push_digit, r_count != pse_pkg::DEPTH_CNT, "digit pushed onto a full stack")
    `PSE_ASSERT_SAME(a_ovf_full, i_clk, i_rst_n, i_cmd.emit && (r_status == pse_pkg::ST_OVERFLOW), r_count == pse_pkg::DEPTH_CNT, "overflow reported below full depth")
    `PSE_ASSERT_NEXT(a_end_clears, i_clk, i_rst_n, i_cmd.emit && r_end, r_count == '0, "stack not cleared after end of expression")

endmodule

@@ dv/tb_postfix_stack_evaluator_core.sv @@
// ----------------------------------------------------------------------------
// Postfix stack evaluator testbench
// Feeds postfix expressions one character per request, predicts the stack top,
// depth, status and end flag for each, and compares every result to the prediction.
// ----------------------------------------------------------------------------
module tb_postfix_stack_evaluator_core;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] sym;
        logic       last;
    } t_char_req;

    typedef struct packed {
        logic [31:0] top;
        logic [3:0]  depth;
        logic [2:0]  status;
        logic        last;
    } t_stack_report;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata  = '0;
    logic        i_s_axis_tlast  = 1'b0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [39:0] o_m_axis_tdata;
    logic [2:0]  o_m_axis_tuser;
    logic        o_m_axis_tlast;

    t_char_req     char_stream[$];
    t_stack_report predicted_reports[$];

    // Shadow of the evaluator's stack.
    logic [31:0] stack_mem [pse_pkg::STACK_DEPTH];
    int unsigned stack_fill = 0;

    int  err_cnt      = 0;
    int  results_seen = 0;
    logic req_taken   = 1'b0;

    int burst_left = 1;
    int gap_left   = 0;

    int  seg_left    = 0;
    int  seg_mode    = 0;
    int  hold_cycles = 0;
    bit  hold_done   = 1'b0;

    postfix_stack_evaluator_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),   // [7:0] symbol
        .i_s_axis_tlast  (i_s_axis_tlast),   // expr_end
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),   // [31:0] top_value, [35:32] stack_depth
        .o_m_axis_tuser  (o_m_axis_tuser),   // [2:0] status
        .o_m_axis_tlast  (o_m_axis_tlast)    // final_result
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [31:0] pop_operand(inout logic short_pop);
        if (stack_fill == 0) begin
            short_pop = 1'b1;
            return '0;
        end
        stack_fill--;
        return stack_mem[stack_fill];
    endfunction

    function automatic t_stack_report eval_symbol(input logic [7:0] sym, input logic last);
        t_stack_report rep;
        logic [31:0]   lhs;
        logic [31:0]   rhs;
        logic [31:0]   res;
        logic          short_pop;
        longint        quo;
        rep.status = pse_pkg::ST_OK;
        short_pop  = 1'b0;
        res        = '0;
        if (sym >= pse_pkg::CH_ZERO && sym <= pse_pkg::CH_NINE) begin
            if (stack_fill < pse_pkg::STACK_DEPTH) begin
                stack_mem[stack_fill] = 32'(sym - pse_pkg::CH_ZERO);
                stack_fill++;
            end else begin
                rep.status = pse_pkg::ST_OVERFLOW;
            end
        end else if (sym == pse_pkg::CH_PLUS || sym == pse_pkg::CH_MINUS ||
                     sym == pse_pkg::CH_STAR || sym == pse_pkg::CH_SLASH) begin
            rhs = pop_operand(short_pop);
            lhs = pop_operand(short_pop);
            if (sym == pse_pkg::CH_PLUS) begin
                res = lhs + rhs;
            end else if (sym == pse_pkg::CH_MINUS) begin
                res = lhs - rhs;
            end else if (sym == pse_pkg::CH_STAR) begin
                res = lhs * rhs;
            end else if (rhs == '0) begin
                rep.status = pse_pkg::ST_DIVZERO;
            end else begin
                // Adds one half to the dividend before truncation: (left + 0.5) / right.
                quo = (2 * longint'($signed(lhs)) + 1) / (2 * longint'($signed(rhs)));
                res = quo[31:0];
            end
            if (short_pop) begin
                rep.status = pse_pkg::ST_UNDERFLOW;
            end
            if (stack_fill < pse_pkg::STACK_DEPTH) begin
                stack_mem[stack_fill] = res;
                stack_fill++;
            end
        end else begin
            rep.status = pse_pkg::ST_IGNORED;
        end
        rep.top   = (stack_fill > 0) ? stack_mem[stack_fill - 1] : '0;
        rep.depth = 4'(stack_fill);
        rep.last  = last;
        if (last) begin
            stack_fill = 0;
        end
        return rep;
    endfunction

    function automatic logic [7:0] pick_digit();
        return pse_pkg::CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] pick_oper();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 3) begin
            return pse_pkg::CH_STAR;
        end else if (r < 5) begin
            return pse_pkg::CH_PLUS;
        end else if (r < 8) begin
            return pse_pkg::CH_MINUS;
        end
        return pse_pkg::CH_SLASH;
    endfunction

    function automatic logic [7:0] pick_noise();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while ((c >= pse_pkg::CH_ZERO && c <= pse_pkg::CH_NINE) ||
               c == pse_pkg::CH_PLUS || c == pse_pkg::CH_MINUS ||
               c == pse_pkg::CH_STAR || c == pse_pkg::CH_SLASH) begin
            c = 8'($urandom_range(0, 255));
        end
        return c;
    endfunction

    task automatic queue_char(input logic [7:0] sym, input logic last);
        t_char_req req;
        req.sym  = sym;
        req.last = last;
        char_stream.push_back(req);
    endtask

    // Well formed postfix expression with random content, ending in tlast.
    task automatic queue_expression();
        logic [7:0] syms[$];
        int         n_ops;
        int         ops_done;
        int         depth;
        n_ops    = $urandom_range(1, 10);
        ops_done = 0;
        depth    = 0;
        while (ops_done < n_ops || depth != 1) begin
            if (depth < 2 || (depth < 7 && ops_done + depth - 1 < n_ops &&
                              $urandom_range(0, 2) == 0)) begin
                syms.push_back(pick_digit());
                depth++;
            end else begin
                syms.push_back(pick_oper());
                depth--;
                ops_done++;
            end
            if ($urandom_range(0, 19) == 0) begin
                syms.push_back(pick_noise());
            end
        end
        foreach (syms[i]) begin
            queue_char(syms[i], i == syms.size() - 1);
        end
    endtask

    // Broken or random sequences: underflows, overflows and stray characters.
    task automatic queue_noise_run();
        int         n;
        logic [7:0] c;
        if ($urandom_range(0, 3) == 0) begin
            n = $urandom_range(9, 12);
            for (int i = 0; i < n; i++) begin
                queue_char(pick_digit(), (i == n - 1) && $urandom_range(0, 1) == 1);
            end
        end else begin
            n = $urandom_range(1, 10);
            for (int i = 0; i < n; i++) begin
                case ($urandom_range(0, 3))
                    0:       c = pick_digit();
                    1:       c = pick_oper();
                    2:       c = 8'($urandom_range(0, 255));
                    default: c = pick_noise();
                endcase
                queue_char(c, $urandom_range(0, 4) == 0);
            end
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            err_cnt++;
        end
    endtask

    // Request driver: bursts of random length separated by random gaps.
    always @(negedge i_clk) begin : req_driver
        t_char_req req;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || req_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                i_s_axis_tvalid <= 1'b0;
            end else if (char_stream.size() > 0) begin
                req = char_stream.pop_front();
                i_s_axis_tdata  <= req.sym;
                i_s_axis_tlast  <= req.last;
                i_s_axis_tvalid <= 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver: segments of different stall patterns, plus one long hold-off
    // so that a result waits, the next request completes and the input stalls.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles--;
            i_m_axis_tready <= 1'b0;
        end else if (!hold_done && results_seen >= 400) begin
            hold_done   = 1'b1;
            hold_cycles = 400;
            i_m_axis_tready <= 1'b0;
        end else begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(20, 200);
                seg_mode = $urandom_range(0, 3);
            end
            seg_left--;
            case (seg_mode)
                0:       i_m_axis_tready <= 1'b1;
                1:       i_m_axis_tready <= 1'($urandom_range(0, 1));
                2:       i_m_axis_tready <= ($urandom_range(0, 7) != 0);
                default: i_m_axis_tready <= ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    // Monitor: predicts on each accepted request, checks each accepted result.
    always @(posedge i_clk) begin : stream_monitor
        t_stack_report exp_r;
        if (!i_rst_n) begin
            req_taken <= 1'b0;
        end else begin
            req_taken <= i_s_axis_tvalid && o_s_axis_tready;
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                predicted_reports.push_back(eval_symbol(i_s_axis_tdata, i_s_axis_tlast));
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                results_seen <= results_seen + 1;
                if (predicted_reports.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual tdata %0h",
                             $time, o_m_axis_tdata);
                    err_cnt++;
                end else begin
                    exp_r = predicted_reports.pop_front();
                    check_field("top_value", exp_r.top, o_m_axis_tdata[31:0]);
                    check_field("stack_depth", 32'(exp_r.depth), 32'(o_m_axis_tdata[35:32]));
                    check_field("status", 32'(exp_r.status), 32'(o_m_axis_tuser));
                    check_field("final_result", 32'(exp_r.last), 32'(o_m_axis_tlast));
                end
            end
        end
    end

    initial begin
        // Directed opening: underflow with a zero divisor, lone-operand underflow,
        // ignored characters, a full stack, a zero divisor and an ordinary division.
        queue_char(pse_pkg::CH_SLASH, 1'b0);
        queue_char(pse_pkg::CH_PLUS, 1'b0);
        queue_char(8'hFF, 1'b1);
        queue_char(pse_pkg::CH_ZERO, 1'b0);
        queue_char(pse_pkg::CH_NINE, 1'b0);
        for (int d = 1; d <= 7; d++) begin
            queue_char(pse_pkg::CH_ZERO + 8'(d), 1'b0);
        end
        queue_char(pse_pkg::CH_STAR, 1'b0);
        queue_char(pse_pkg::CH_MINUS, 1'b0);
        queue_char(pse_pkg::CH_ZERO, 1'b0);
        queue_char(pse_pkg::CH_SLASH, 1'b0);
        queue_char(8'h00, 1'b1);
        queue_char(pse_pkg::CH_ZERO + 8'd7, 1'b0);
        queue_char(pse_pkg::CH_ZERO + 8'd2, 1'b0);
        queue_char(pse_pkg::CH_SLASH, 1'b1);

        while (char_stream.size() < 1970) begin
            if ($urandom_range(0, 9) < 8) begin
                queue_expression();
            end else begin
                queue_noise_run();
            end
        end

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (char_stream.size() != 0 || i_s_axis_tvalid) begin
            @(posedge i_clk);
        end
        while (predicted_reports.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (60) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("tb_postfix_stack_evaluator_core passed");
        end else begin
            $display("tb_postfix_stack_evaluator_core failed");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("tb_postfix_stack_evaluator_core failed");
        $finish;
    end

endmodule
